// ===== sv/rbe_pkg.sv =====
package rbe_pkg;

  // Width of the internal coordinate datapath; coordinates are scaled into a 60-bit frame.
  localparam int XW = 64;
  localparam int FRAME_BITS = 60;
  localparam int ZW = 32;
  localparam int HW = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [ZW-1:0] ROUND_HALF = 32'h0000_8000;

  // Payload that travels down the CORDIC pipeline, with its valid bit.
  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ZW-1:0]        z;
    logic [HW-1:0]        heading;
  } rbe_cordic_t;

  // Arc tangent of 2^-i in units of 2^-32 turn, truncated.
  function automatic logic [ZW-1:0] atan_turn(input logic [4:0] idx);
    logic [ZW-1:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051D;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2E;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2F9;
      5'd15:   a = 32'h0000_517C;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A2F;
      5'd19:   a = 32'h0000_0517;
      5'd20:   a = 32'h0000_028B;
      5'd21:   a = 32'h0000_0145;
      5'd22:   a = 32'h0000_00A2;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/rbe_if.sv =====
// Input channel: target offset and own heading.
interface rbe_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] offset_x;
  logic signed [COORD_BITS-1:0] offset_y;
  logic [15:0]                  heading;

  modport source (output valid, output offset_x, output offset_y, output heading,
                  input ready);
  modport sink (input valid, input offset_x, input offset_y, input heading,
                output ready);
endinterface

// Result channel: wrapped steering error.
interface rbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] bearing_error;

  modport source (output valid, output bearing_error, input ready);
  modport sink (input valid, input bearing_error, output ready);
endinterface

// ===== sv/rbe_prep.sv =====
module rbe_prep import rbe_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] offset_x,
  input  logic signed [COORD_BITS-1:0] offset_y,
  input  logic [HW-1:0]                heading,
  output rbe_cordic_t                  q
);

  localparam int SCALE_SHIFT = FRAME_BITS - COORD_BITS;

  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;
  logic                 left;
  rbe_cordic_t          q_r;
  rbe_cordic_t          q_nxt;

  // Sign-extend, fold the left half-plane onto the right one and scale into the frame.
  always_comb begin
    xe = XW'(offset_x);
    ye = XW'(offset_y);
    left = xe[XW-1];
    q_nxt.vld = in_vld;
    q_nxt.zero = (offset_x == '0) && (offset_y == '0);
    q_nxt.x = (left ? -xe : xe) <<< SCALE_SHIFT;
    q_nxt.y = (left ? -ye : ye) <<< SCALE_SHIFT;
    q_nxt.z = left ? HALF_TURN : '0;
    q_nxt.heading = heading;
  end

  // Valid bit is control state and is reset; the payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= q_nxt.vld;
    end
    if (en) begin
      q_r.zero <= q_nxt.zero;
      q_r.x <= q_nxt.x;
      q_r.y <= q_nxt.y;
      q_r.z <= q_nxt.z;
      q_r.heading <= q_nxt.heading;
    end
  end

  assign q = q_r;

endmodule

// ===== sv/rbe_cordic_stage.sv =====
module rbe_cordic_stage import rbe_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  rbe_cordic_t d,
  output rbe_cordic_t q
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  rbe_cordic_t          q_r;
  rbe_cordic_t          q_nxt;

  // One vectoring rotation: drive y toward zero and accumulate the angle.
  always_comb begin
    xs = d.x >>> STEP;
    ys = d.y >>> STEP;
    q_nxt = d;
    if (d.y[XW-1]) begin
      q_nxt.x = d.x - ys;
      q_nxt.y = d.y + xs;
      q_nxt.z = d.z - atan_turn(5'(STEP));
    end else begin
      q_nxt.x = d.x + ys;
      q_nxt.y = d.y - xs;
      q_nxt.z = d.z + atan_turn(5'(STEP));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= q_nxt.vld;
    end
    if (en) begin
      q_r.zero <= q_nxt.zero;
      q_r.x <= q_nxt.x;
      q_r.y <= q_nxt.y;
      q_r.z <= q_nxt.z;
      q_r.heading <= q_nxt.heading;
    end
  end

  assign q = q_r;

endmodule

// ===== sv/rbe_wrap.sv =====
module rbe_wrap import rbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  rbe_cordic_t        d,
  output logic               out_vld,
  output logic signed [15:0] out_err
);

  logic [ZW-1:0]      dir;
  logic [ZW-1:0]      err;
  logic [ZW-1:0]      rnd;
  logic               vld_r;
  logic signed [15:0] err_r;
  logic signed [15:0] err_nxt;

  // Subtract the heading modulo one turn and round to 16 bits.
  always_comb begin
    dir = d.zero ? '0 : d.z;
    err = dir - {d.heading, 16'h0000};
    rnd = err + ROUND_HALF;
    err_nxt = signed'(rnd[ZW-1:ZW-16]);
  end

  // Output register; it holds while the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= err_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_err = err_r;

endmodule

// ===== sv/relative_bearing_error_top.sv =====
// Channel   Direction  Payload                                  Transfer
// in_ch     input      offset_x, offset_y (COORD_BITS), heading   valid && ready
// out_ch    output     bearing_error (16, signed)                 valid && ready
//
// One item is taken per cycle while the output does not stall; each result passes
// CORDIC_STEPS + 2 registers: one for sign folding and scaling, one per CORDIC
// rotation, one for the heading wrap and rounding.
// Reset clears only the valid bits of the stages.
// A stall on the output freezes the whole pipeline; in_ch.ready is low only while
// the output register holds a result that has not been taken.
module relative_bearing_error_top import rbe_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rbe_in_if.sink     in_ch,
  rbe_out_if.source  out_ch
);

  logic        en;
  logic        out_vld;
  rbe_cordic_t stg [0:CORDIC_STEPS];

  // Pipeline advances whenever the output register is empty or being drained.
  assign en = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  rbe_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_ch.valid),
    .offset_x (in_ch.offset_x),
    .offset_y (in_ch.offset_y),
    .heading  (in_ch.heading),
    .q        (stg[0])
  );

  // One registered stage per CORDIC rotation.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    rbe_cordic_stage #(.STEP(i)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (stg[i]),
      .q     (stg[i+1])
    );
  end

  rbe_wrap u_wrap (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .d       (stg[CORDIC_STEPS]),
    .out_vld (out_vld),
    .out_err (out_ch.bearing_error)
  );

  assign out_ch.valid = out_vld;

endmodule
